### design/lkv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants of the LRU key/value cache
// Sizes of the entry chain and the structs passed between control and cells.
// ----------------------------------------------------------------------------
package lkv_pkg;

    // number of cells in the recency chain
    localparam int NUM_ENTRIES = 16;
    localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // command codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // one entry moving down the chain
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } lkv_entry_t;

    // selection carried up the chain toward cell 0
    typedef struct packed {
        logic             any;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } lkv_sel_t;

    // broadcast control from the controller to every cell
    typedef struct packed {
        logic             cmp_en;
        logic             upd;
        logic [KEY_W-1:0] cmp_key;
    } lkv_ctl_t;

endpackage

### design/lkv_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_cell: one recency position of the LRU chain
// Holds an entry, compares it against the incoming key, and during an update
// takes the entry of its more recent neighbor when a mark lies at or below it.
// ----------------------------------------------------------------------------
module lkv_cell
    import lkv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lkv_ctl_t   ctl,
    input  logic       ins_mark,
    input  lkv_entry_t entry_in,
    output lkv_entry_t entry_out,
    input  lkv_sel_t   sel_in,
    output lkv_sel_t   sel_out,
    output logic       hit
);

    logic             valid_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic             hit_reg;
    logic             mark;
    logic             shift;

    // this cell is the one being promoted or replaced
    assign mark  = hit_reg | ins_mark;
    // shift when the marked cell is here or further down the chain
    assign shift = ctl.upd & (mark | sel_in.any);

    assign sel_out.any   = mark | sel_in.any;
    assign sel_out.key   = mark ? key_reg : sel_in.key;
    assign sel_out.value = mark ? value_reg : sel_in.value;

    assign entry_out.valid = valid_reg;
    assign entry_out.key   = key_reg;
    assign entry_out.value = value_reg;

    assign hit = hit_reg;

    // control state: valid flag and registered match
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.cmp_en)
            begin
                hit_reg <= valid_reg & (key_reg == ctl.cmp_key);
            end
            else if (ctl.upd)
            begin
                hit_reg <= 1'b0;
            end
            if (shift)
            begin
                valid_reg <= entry_in.valid;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg   <= entry_in.key;
            value_reg <= entry_in.value;
        end
    end

endmodule

### design/lkv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_ctrl: transaction control of the LRU key/value cache
// Latches a request, tracks occupancy and capacity, picks the insertion or
// eviction position and registers the one-cycle result.
// ----------------------------------------------------------------------------
module lkv_ctrl
    import lkv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   command,
    input  logic [KEY_W-1:0]       key,
    input  logic [VAL_W-1:0]       value,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CAP_W-1:0]       cfg_data,
    output logic                   done,
    output logic                   found,
    output logic [VAL_W-1:0]       read_value,
    output logic                   evicted,
    output logic [KEY_W-1:0]       evicted_key,
    input  logic [NUM_ENTRIES-1:0] hit_vec,
    input  lkv_sel_t               sel,
    output lkv_ctl_t               ctl,
    output logic [NUM_ENTRIES-1:0] ins_mark,
    output lkv_entry_t             head
);

    logic             busy_reg;
    logic             done_reg;
    logic             cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    logic [CAP_W-1:0] cap_reg;

    logic             found_reg;
    logic [VAL_W-1:0] read_value_reg;
    logic             evicted_reg;
    logic [KEY_W-1:0] evicted_key_reg;

    logic             accept;
    logic             hit_any;
    logic             put_miss;
    logic             evict;
    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] eff_cap;
    logic [CNT_W-1:0] occ_m1;
    logic [IDX_W-1:0] ins_pos;

    assign accept    = start & ~busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = 1'b1;

    assign done        = done_reg;
    assign found       = found_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

    // compare runs in the accept cycle against the port key
    assign ctl.cmp_en  = accept;
    assign ctl.upd     = busy_reg;
    assign ctl.cmp_key = key;

    // effective capacity: zero acts as one, clipped at the chain length
    assign cap_ext = CMP_W'(cap_reg);
    always_comb
    begin
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(NUM_ENTRIES))
        begin
            eff_cap = CMP_W'(NUM_ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign hit_any  = |hit_vec;
    assign put_miss = (cmd_reg == CMD_PUT) & ~hit_any;
    assign evict    = put_miss & (CMP_W'(occ_reg) >= eff_cap);

    // evict replaces the least recent cell, otherwise fill the first free one
    assign occ_m1  = occ_reg - CNT_W'(1);
    assign ins_pos = evict ? occ_m1[IDX_W-1:0] : occ_reg[IDX_W-1:0];

    always_comb
    begin
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            ins_mark[i] = busy_reg & put_miss & (ins_pos == IDX_W'(i));
        end
    end

    // new head entry: the request key, with new or promoted value
    assign head.valid = 1'b1;
    assign head.key   = key_reg;
    assign head.value = (cmd_reg == CMD_PUT) ? value_reg : sel.value;

    assign occ_next = (busy_reg & put_miss & ~evict) ? occ_reg + CNT_W'(1) : occ_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            occ_reg  <= '0;
            cap_reg  <= CAP_RESET;
        end
        else
        begin
            busy_reg <= accept;
            done_reg <= busy_reg;
            occ_reg  <= occ_next;
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= command;
            key_reg   <= key;
            value_reg <= value;
        end
        if (busy_reg)
        begin
            found_reg       <= hit_any;
            read_value_reg  <= ((cmd_reg == CMD_GET) & hit_any) ? sel.value : '0;
            evicted_reg     <= evict;
            evicted_key_reg <= evict ? sel.key : '0;
        end
    end

`ifndef SYNTH
    // an update cycle is always followed by exactly one result strobe
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |=> done_reg)
        else $error("result strobe missing after update");
    // keys in the chain stay distinct
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> $onehot0(hit_vec))
        else $error("more than one cell matched");
    // occupancy never exceeds the chain length
    assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(occ_reg) <= CMP_W'(NUM_ENTRIES))
        else $error("occupancy overflow");
    // a hit never evicts
    assert property (@(posedge clk) disable iff (!rst_n) (done_reg & evicted_reg) |-> !found_reg)
        else $error("eviction reported on a hit");
`endif

endmodule

### design/lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value cache, LRU replacement
// Entries are kept in a chain of cells ordered by recency; cell 0 is the
// most recent and the valid cells form a prefix of the chain.
// ----------------------------------------------------------------------------
// Usage: a transaction is taken when start is high and busy is low. The
// key is compared against all cells in the accept cycle, and in the next
// cycle (busy high) the chain from cell 0 down to the promoted or inserted
// position shifts one place toward the tail. The result appears
// for exactly one cycle with done high, in the cycle after busy; the receiver
// cannot stall it, so it must capture it then. A new transaction may start in
// that same cycle. The capacity register is written over cfg_valid/cfg_data
// (cfg_ready is always high) and must only change while no transaction is in
// flight. Reset clears all entries at once; no clearing pass is needed.
module lru_key_value_cache
    import lkv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             command,
    input  logic [KEY_W-1:0] key,
    input  logic [VAL_W-1:0] value,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data,
    output logic             done,
    output logic             found,
    output logic [VAL_W-1:0] read_value,
    output logic             evicted,
    output logic [KEY_W-1:0] evicted_key
);

    lkv_ctl_t               ctl;
    lkv_entry_t             head;
    logic [NUM_ENTRIES-1:0] hit_vec;
    logic [NUM_ENTRIES-1:0] ins_mark;
    lkv_entry_t             entry_chain [NUM_ENTRIES+1];
    lkv_sel_t               sel_chain   [NUM_ENTRIES+1];

    // chain ends: head entry enters cell 0, nothing selected past the tail
    assign entry_chain[0]         = head;
    assign sel_chain[NUM_ENTRIES] = '0;

    lkv_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .key         (key),
        .value       (value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .done        (done),
        .found       (found),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key),
        .hit_vec     (hit_vec),
        .sel         (sel_chain[0]),
        .ctl         (ctl),
        .ins_mark    (ins_mark),
        .head        (head)
    );

    // recency chain
    for (genvar i = 0; i < NUM_ENTRIES; i++)
    begin : g_cell
        lkv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .ins_mark  (ins_mark[i]),
            .entry_in  (entry_chain[i]),
            .entry_out (entry_chain[i+1]),
            .sel_in    (sel_chain[i+1]),
            .sel_out   (sel_chain[i]),
            .hit       (hit_vec[i])
        );
    end

endmodule

### bench/lru_key_value_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb: self-checking bench for the LRU key/value cache
// Drives get/put transactions through the start/busy port and checks every
// done strobe against an in-bench LRU predictor or a typed result. A directed
// table runs first: reset misses, key and value extremes, hit update, and the
// capacity corners (zero, above the entry count, lowered below the fill
// level). Random phases follow, each at its own capacity setting, using keys
// from a small pool so that hits, updates and evictions are frequent.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb
    import lkv_pkg::*;
;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 11;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int ITEMS_PER_SET  = 50;
    localparam int NUM_SETS       = 9;
    localparam int KEY_POOL_SIZE  = 32;
    localparam int MAX_PRINTED    = 40;

    // one result of the cache
    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } cache_result_t;

    typedef enum logic [1:0] {
        ROW_PREDICT,    // checked against the predictor
        ROW_KNOWN,      // checked against the typed result
        ROW_CAPACITY    // capacity write, value[CAP_W-1:0] holds the setting
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic             cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        cache_result_t    want;
    } stim_row_t;

    localparam cache_result_t NO_RESULT = '0;
    localparam int NUM_ROWS = 26;

    // directed table
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // empty cache: both key extremes miss
        '{ROW_KNOWN,    CMD_GET, 32'h0000_0000, 32'h0000_0000, '{1'b0, 32'h0, 1'b0, 32'h0}},
        '{ROW_KNOWN,    CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, '{1'b0, 32'h0, 1'b0, 32'h0}},
        // inserts with value extremes
        '{ROW_KNOWN,    CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF, '{1'b0, 32'h0, 1'b0, 32'h0}},
        '{ROW_KNOWN,    CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000, '{1'b0, 32'h0, 1'b0, 32'h0}},
        '{ROW_KNOWN,    CMD_GET, 32'h0000_0000, 32'h0000_0000,
          '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
        '{ROW_KNOWN,    CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, '{1'b1, 32'h0, 1'b0, 32'h0}},
        // put hit overwrites
        '{ROW_KNOWN,    CMD_PUT, 32'h0000_0000, 32'h1234_5678, '{1'b1, 32'h0, 1'b0, 32'h0}},
        '{ROW_KNOWN,    CMD_GET, 32'h0000_0000, 32'h0000_0000,
          '{1'b1, 32'h1234_5678, 1'b0, 32'h0}},
        // capacity zero acts as one, two entries already held
        '{ROW_CAPACITY, CMD_GET, 32'h0000_0000, 32'h0000_0000, NO_RESULT},
        '{ROW_KNOWN,    CMD_PUT, 32'hA5A5_A5A5, 32'h0000_0001,
          '{1'b0, 32'h0, 1'b1, 32'hFFFF_FFFF}},
        '{ROW_KNOWN,    CMD_PUT, 32'h5A5A_5A5A, 32'h0000_0002, '{1'b0, 32'h0, 1'b1, 32'h0}},
        // hits never evict
        '{ROW_KNOWN,    CMD_GET, 32'hA5A5_A5A5, 32'h0000_0000, '{1'b1, 32'h1, 1'b0, 32'h0}},
        '{ROW_KNOWN,    CMD_PUT, 32'h5A5A_5A5A, 32'h0000_0003, '{1'b1, 32'h0, 1'b0, 32'h0}},
        '{ROW_PREDICT,  CMD_PUT, 32'h0000_0001, 32'h0000_0004, NO_RESULT},
        '{ROW_PREDICT,  CMD_GET, 32'h5A5A_5A5A, 32'h0000_0000, NO_RESULT},
        // capacity above the entry count
        '{ROW_CAPACITY, CMD_GET, 32'h0000_0000, 32'h0000_001F, NO_RESULT},
        '{ROW_PREDICT,  CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, NO_RESULT},
        '{ROW_PREDICT,  CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, NO_RESULT},
        '{ROW_PREDICT,  CMD_GET, 32'h8000_0000, 32'h0000_0000, NO_RESULT},
        // capacity one, well below the fill level
        '{ROW_CAPACITY, CMD_GET, 32'h0000_0000, 32'h0000_0001, NO_RESULT},
        '{ROW_PREDICT,  CMD_PUT, 32'h0000_FFFF, 32'hFFFF_0000, NO_RESULT},
        '{ROW_PREDICT,  CMD_GET, 32'h0000_FFFF, 32'h0000_0000, NO_RESULT},
        '{ROW_PREDICT,  CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, NO_RESULT},
        '{ROW_CAPACITY, CMD_GET, 32'h0000_0000, 32'h0000_0011, NO_RESULT},
        '{ROW_PREDICT,  CMD_PUT, 32'hDEAD_BEEF, 32'hCAFE_F00D, NO_RESULT},
        '{ROW_PREDICT,  CMD_GET, 32'hDEAD_BEEF, 32'h0000_0000, NO_RESULT}
    };

    // capacity setting of each random phase
    localparam logic [CAP_W-1:0] PHASE_CAPACITY [NUM_SETS] = '{
        5'd16, 5'd4, 5'd0, 5'd1, 5'd31, 5'd7, 5'd17, 5'd2, 5'd16
    };

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             start       = 1'b0;
    logic             command     = CMD_GET;
    logic [KEY_W-1:0] key         = '0;
    logic [VAL_W-1:0] value       = '0;
    logic             cfg_valid   = 1'b0;
    logic [CAP_W-1:0] cfg_data    = '0;
    logic             busy;
    logic             cfg_ready;
    logic             done;
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;

    // predictor state
    logic [KEY_W-1:0] model_key   [NUM_ENTRIES];
    logic [VAL_W-1:0] model_value [NUM_ENTRIES];
    bit               model_valid [NUM_ENTRIES];
    int unsigned      model_age   [NUM_ENTRIES];
    int unsigned      model_fill;
    logic [CAP_W-1:0] model_capacity;

    cache_result_t    expected_results [$];
    logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

    int mismatch_count  = 0;
    int cycle_count     = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int hits_seen       = 0;
    int evictions_seen  = 0;
    int capacity_writes = 0;
    int sender_idle_pct = 19;

    lru_key_value_cache i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .key         (key),
        .value       (value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .done        (done),
        .found       (found),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

    always #CLK_HALF clk = ~clk;

    // cycle counter and watchdog
    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results pending",
                 cycle_count, expected_results.size());
        $display("lru_key_value_cache_tb: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // capacity as the cache applies it
    function automatic int unsigned effective_capacity();
        if (model_capacity == 0)
            return 1;
        if (model_capacity > NUM_ENTRIES)
            return NUM_ENTRIES;
        return 32'(model_capacity);
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            model_valid[i] = 1'b0;
            model_age[i]   = 0;
        end
        model_fill     = 0;
        model_capacity = CAP_RESET;
    endfunction

    // LRU predictor: applies one transaction, returns its result
    function automatic cache_result_t cache_access(input logic cmd,
                                                   input logic [KEY_W-1:0] k,
                                                   input logic [VAL_W-1:0] v);
        cache_result_t res;
        int            hit;
        int            victim;
        int            slot;
        int unsigned   oldest;
        int unsigned   rank;

        res  = '0;
        hit  = -1;
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (hit < 0 && model_valid[i] && model_key[i] == k)
                hit = i;

        if (hit >= 0)
        begin
            // hit: read or overwrite, then promote to most recent
            res.found = 1'b1;
            if (cmd == CMD_GET)
                res.read_value = model_value[hit];
            else
                model_value[hit] = v;
            rank = model_age[hit];
            for (int i = 0; i < NUM_ENTRIES; i++)
                if (model_valid[i] && i != hit && model_age[i] < rank)
                    model_age[i]++;
            model_age[hit] = 0;
        end
        else if (cmd == CMD_PUT)
        begin
            // miss on put: evict one entry when at or above capacity
            if (model_fill >= effective_capacity())
            begin
                victim = -1;
                oldest = 0;
                for (int i = 0; i < NUM_ENTRIES; i++)
                    if (model_valid[i] && (victim < 0 || model_age[i] > oldest))
                    begin
                        victim = i;
                        oldest = model_age[i];
                    end
                if (victim >= 0)
                begin
                    res.evicted       = 1'b1;
                    res.evicted_key   = model_key[victim];
                    model_valid[victim] = 1'b0;
                    model_age[victim]   = 0;
                    if (model_fill > 0)
                        model_fill--;
                end
            end
            slot = -1;
            for (int i = 0; i < NUM_ENTRIES; i++)
                if (slot < 0 && !model_valid[i])
                    slot = i;
            if (slot >= 0)
            begin
                for (int i = 0; i < NUM_ENTRIES; i++)
                    if (model_valid[i])
                        model_age[i]++;
                model_valid[slot] = 1'b1;
                model_key[slot]   = k;
                model_value[slot] = v;
                model_age[slot]   = 0;
                model_fill++;
            end
        end
        return res;
    endfunction

    // drop start and wait until every pending result has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        model_capacity = cap;
        capacity_writes++;
        cfg_valid <= 1'b0;
    endtask

    // one transaction: optional idle gap, handshake, then prediction
    task automatic run_item(input logic cmd, input logic [KEY_W-1:0] k,
                            input logic [VAL_W-1:0] v, input bit use_typed,
                            input cache_result_t typed_want);
        cache_result_t want;

        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        key     <= k;
        value   <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        want = cache_access(cmd, k, v);
        if (use_typed)
            want = typed_want;
        expected_results.push_back(want);
        items_sent++;
        hits_seen      += int'(want.found);
        evictions_seen += int'(want.evicted);
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        cache_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with no pending transaction", read_value, '0);
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (found !== want.found)
                    report_mismatch("found", 32'(found), 32'(want.found));
                if (read_value !== want.read_value)
                    report_mismatch("read_value", read_value, want.read_value);
                if (evicted !== want.evicted)
                    report_mismatch("evicted", 32'(evicted), 32'(want.evicted));
                if (evicted_key !== want.evicted_key)
                    report_mismatch("evicted_key", evicted_key, want.evicted_key);
            end
        end
    end

    // main sequence
    initial
    begin
        stim_row_t   row;
        int unsigned window;
        logic [KEY_W-1:0] k;

        clear_model();
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        sender_idle_pct = 19;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_CAPACITY)
                write_capacity(row.value[CAP_W-1:0]);
            else
                run_item(row.cmd, row.key, row.value, row.kind == ROW_KNOWN, row.want);
        end

        // random phases, each at its own capacity
        for (int p = 0; p < NUM_SETS; p++)
        begin
            write_capacity(PHASE_CAPACITY[p]);
            sender_idle_pct = (p < 3) ? 19 : (p < 6) ? 46 : 0;
            window = effective_capacity() + $urandom_range(1, 6);
            if (window > KEY_POOL_SIZE)
                window = KEY_POOL_SIZE;
            for (int n = 0; n < ITEMS_PER_SET; n++)
            begin
                if ($urandom_range(0, 99) < 2)
                    wait_drained();
                if ($urandom_range(0, 99) < 80)
                    k = key_pool[$urandom_range(0, window - 1)];
                else
                    k = $urandom;
                run_item(($urandom_range(0, 99) < 55) ? CMD_PUT : CMD_GET, k, $urandom,
                         1'b0, NO_RESULT);
            end
        end

        // drain and let the pipeline settle
        wait_drained();
        repeat (4) @(posedge clk);

        $display("covered %0d transactions (%0d hits, %0d evictions) over %0d capacity writes",
                 items_sent, hits_seen, evictions_seen, capacity_writes);
        $display("compared %0d results, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("lru_key_value_cache_tb: done, clean");
        else
            $display("lru_key_value_cache_tb: done, errors");
        $finish;
    end

endmodule

### lru_key_value_cache.f
design/lkv_pkg.sv
design/lkv_cell.sv
design/lkv_ctrl.sv
design/lru_key_value_cache.sv
bench/lru_key_value_cache_tb.sv
